// ===== hw/rtl/ghalloc_pkg.sv =====
// ----------------------------------------------------------------------------
// ghalloc_pkg
// Shared types and constants of the generational handle allocator.
// ----------------------------------------------------------------------------
package ghalloc_pkg;

  // Pool size, slot 0 included (slot 0 is the nil handle)
  localparam int unsigned SLOTS = 1024;
  localparam int unsigned IDX_W = $clog2(SLOTS);

  localparam logic [15:0] SLOTS_16   = 16'(SLOTS);
  localparam logic [15:0] LINK_END   = 16'hFFFF;
  localparam logic [15:0] LINK_INUSE = 16'hFFFE;
  localparam logic [15:0] SALT_NIL   = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_RENT     = 2'd0,
    OP_RETURN   = 2'd1,
    OP_VALIDATE = 2'd2,
    OP_QUERY    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_EXHAUSTED = 3'd1,
    STS_RANGE     = 3'd2,
    STS_NOT_USED  = 3'd3,
    STS_MISMATCH  = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Write request from the control logic into the slot store
  typedef struct packed {
    logic             salt_we;
    logic             link_we;
    logic [IDX_W-1:0] addr;
    logic [15:0]      salt;
    logic [15:0]      link;
  } mem_wr_t;

endpackage

// ===== hw/rtl/ghalloc_if.sv =====
// ----------------------------------------------------------------------------
// ghalloc_req_if / ghalloc_rsp_if
// Valid/ready channels for requests into and results out of the allocator.
// ----------------------------------------------------------------------------
interface ghalloc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] handle_salt;
  logic [15:0] handle_index;

  modport source (output valid, op, handle_salt, handle_index, input ready);
  modport sink   (input valid, op, handle_salt, handle_index, output ready);
endinterface

interface ghalloc_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] granted_salt;
  logic [15:0] granted_index;
  logic        answer_flag;
  logic [2:0]  status;

  modport source (output valid, granted_salt, granted_index, answer_flag, status,
                  input ready);
  modport sink   (input valid, granted_salt, granted_index, answer_flag, status,
                  output ready);
endinterface

// ===== hw/rtl/ghalloc_store.sv =====
// ----------------------------------------------------------------------------
// ghalloc_store
// Salt and link memories of the slot pool, with the initialization sweep
// that builds the free chain after reset.
// ----------------------------------------------------------------------------
module ghalloc_store
  import ghalloc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  input  mem_wr_t          wr_i,
  output logic [15:0]      salt_o,
  output logic [15:0]      link_o,
  output logic             ready_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  logic [15:0] salt_mem [SLOTS];
  logic [15:0] link_mem [SLOTS];
  logic [15:0] salt_rd_q;
  logic [15:0] link_rd_q;

  logic             clr_busy_q, clr_busy_d;
  logic [IDX_W-1:0] clr_cnt_q, clr_cnt_d;
  mem_wr_t          wr;

  // Sweep every slot once after reset
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == LAST_IDX) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  // Select the sweep or the control logic as the writer
  always_comb begin
    wr = wr_i;
    if (clr_busy_q) begin
      wr.salt_we = 1'b1;
      wr.link_we = 1'b1;
      wr.addr    = clr_cnt_q;
      if (clr_cnt_q == '0) begin
        wr.salt = SALT_NIL;
        wr.link = LINK_INUSE;
      end else if (clr_cnt_q == IDX_W'(1)) begin
        wr.salt = '0;
        wr.link = LINK_END;
      end else begin
        wr.salt = '0;
        wr.link = 16'(clr_cnt_q) - 16'd1;
      end
    end
  end

  // Salt memory
  always_ff @(posedge clk_i) begin
    if (wr.salt_we) begin
      salt_mem[wr.addr] <= wr.salt;
    end
    if (rd_en_i) begin
      salt_rd_q <= salt_mem[rd_addr_i];
    end
  end

  // Link memory
  always_ff @(posedge clk_i) begin
    if (wr.link_we) begin
      link_mem[wr.addr] <= wr.link;
    end
    if (rd_en_i) begin
      link_rd_q <= link_mem[rd_addr_i];
    end
  end

  assign salt_o  = salt_rd_q;
  assign link_o  = link_rd_q;
  assign ready_o = !clr_busy_q;

endmodule

// ===== hw/rtl/generational_handle_allocator.sv =====
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Hands out salted slot handles from a LIFO free list; checks and takes back.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per transfer: rent, return a handle, validate
//   a handle, or query whether a slot is in use. rsp carries exactly one
//   result per request, in request order.
//   Each request is handled in two steps: on acceptance the slot's salt and
//   link are read into the pool memories' read registers; in the execute
//   state they are checked, written back and the result register is loaded.
//   The head slot's link must be read before the next pop, so a new request
//   is taken only after the execute state of the last one has finished.
//   After reset the block sweeps all SLOTS (1024) memory entries, one per
//   cycle, to build the free chain; req.ready stays low for those cycles.
//   A result waits in its register while rsp.ready is low; the next request
//   is accepted only once that register is free or emptied the same cycle.
// ----------------------------------------------------------------------------
module generational_handle_allocator
  import ghalloc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  ghalloc_req_if.sink   req,
  ghalloc_rsp_if.source rsp
);

  state_e state_q, state_d;

  logic [15:0] head_q, head_d;
  op_e         op_q;
  logic [15:0] salt_q;
  logic [15:0] idx_q;

  logic        out_valid_q, out_valid_d;
  logic [15:0] out_salt_q, out_salt_d;
  logic [15:0] out_index_q, out_index_d;
  logic        out_flag_q, out_flag_d;
  status_e     out_status_q, out_status_d;

  logic             store_ready;
  logic             req_xfer;
  logic [IDX_W-1:0] rd_addr;
  logic [15:0]      salt_rd;
  logic [15:0]      link_rd;
  mem_wr_t          wr;

  logic head_ok;
  logic idx_ok;

  assign req.ready = (state_q == S_IDLE) && store_ready && (!out_valid_q || rsp.ready);
  assign req_xfer  = req.valid && req.ready;

  // Rent reads the head slot, everything else the addressed slot
  assign rd_addr = (op_e'(req.op) == OP_RENT) ? head_q[IDX_W-1:0]
                                              : req.handle_index[IDX_W-1:0];

  ghalloc_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (req_xfer),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .salt_o    (salt_rd),
    .link_o    (link_rd),
    .ready_o   (store_ready)
  );

  assign head_ok = (head_q != '0) && (head_q < SLOTS_16);
  assign idx_ok  = (idx_q != '0) && (idx_q < SLOTS_16);

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      op_q   <= op_e'(req.op);
      salt_q <= req.handle_salt;
      idx_q  <= req.handle_index;
    end
  end

  // Check, modify and write back; form the result
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    out_valid_d  = out_valid_q;
    out_salt_d   = out_salt_q;
    out_index_d  = out_index_q;
    out_flag_d   = out_flag_q;
    out_status_d = out_status_q;
    wr           = '0;

    if (out_valid_q && rsp.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_xfer) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d      = S_IDLE;
        out_valid_d  = 1'b1;
        out_salt_d   = '0;
        out_index_d  = '0;
        out_flag_d   = 1'b0;
        out_status_d = STS_OK;
        if (op_q == OP_RENT) begin
          if (!head_ok) begin
            out_status_d = STS_EXHAUSTED;
          end else begin
            // Pop the head and mark it in use
            out_salt_d  = salt_rd;
            out_index_d = head_q;
            head_d      = link_rd;
            wr.link_we  = 1'b1;
            wr.addr     = head_q[IDX_W-1:0];
            wr.link     = LINK_INUSE;
          end
        end else if (!idx_ok) begin
          out_status_d = STS_RANGE;
        end else begin
          case (op_q)
            OP_RETURN: begin
              if (link_rd != LINK_INUSE) begin
                out_status_d = STS_NOT_USED;
              end else if (salt_rd != salt_q) begin
                out_status_d = STS_MISMATCH;
              end else begin
                // Bump the salt and push the slot
                wr.salt_we = 1'b1;
                wr.link_we = 1'b1;
                wr.addr    = idx_q[IDX_W-1:0];
                wr.salt    = salt_q + 16'd1;
                wr.link    = head_q;
                head_d     = idx_q;
              end
            end
            OP_VALIDATE: begin
              if (salt_rd == salt_q) begin
                out_flag_d = 1'b1;
              end else begin
                out_status_d = STS_MISMATCH;
              end
            end
            OP_QUERY: begin
              out_flag_d = (link_rd == LINK_INUSE);
            end
            default: begin
              out_status_d = STS_OK;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= SLOTS_16 - 16'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_salt_q   <= out_salt_d;
    out_index_q  <= out_index_d;
    out_flag_q   <= out_flag_d;
    out_status_q <= out_status_d;
  end

  assign rsp.valid         = out_valid_q;
  assign rsp.granted_salt  = out_salt_q;
  assign rsp.granted_index = out_index_q;
  assign rsp.answer_flag   = out_flag_q;
  assign rsp.status        = out_status_q;

  // No request is taken during the initialization sweep
  a_no_xfer_in_init : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer |-> store_ready)
    else $error("request accepted during initialization sweep");

  // A fresh result only comes out of the execute cycle
  a_result_from_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC))
    else $error("result raised outside execute cycle");

  // Free head is either the end marker or a real slot
  a_head_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == LINK_END) || ((head_q != '0) && (head_q < SLOTS_16)))
    else $error("free head corrupt");

  // A granted index is a real slot and comes with status ok
  a_grant_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_index_q != '0)) |->
      ((out_status_q == STS_OK) && (out_index_q < SLOTS_16)))
    else $error("grant with bad index or status");

endmodule
